// ----- rtl/arp_pkg.sv -----
// arp_pkg: shared widths, limits and types for the adaptive redraw pacer
// no dependencies; used by the interfaces, arp_step and adaptive_redraw_pacer_top
package arp_pkg;

	localparam int ELAPSED_W = 16;
	localparam int OPT_W     = 10;
	localparam int WAIT_W    = 14;
	localparam int SCORE_W   = 8;
	localparam int MULT_W    = 5;
	localparam int PERIOD_W  = 14;
	localparam int DIFF_W    = ELAPSED_W - 1;
	localparam int PROD_W    = 15;

	localparam int MAX_MULT_DEF = 16;

	localparam logic signed [SCORE_W-1:0] SCORE_LOW_LIMIT  = -8'sd1;
	localparam logic signed [SCORE_W-1:0] SCORE_HIGH_LIMIT = 8'sd4;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN        = -8'sd128;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX        = 8'sd127;

	localparam logic [OPT_W-1:0]    OPT_RESET    = OPT_W'(1000 / 50);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000 / 50);
	localparam logic [PERIOD_W-1:0] PERIOD_MAX   = '1;
	localparam logic [MULT_W-1:0]   MULT_ONE     = MULT_W'(1);
	localparam logic [WAIT_W-1:0]   WAIT_MIN     = WAIT_W'(1);

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [MULT_W-1:0]         mult;
		logic [PERIOD_W-1:0]       period;
	} arp_state_t;

	typedef struct packed {
		logic signed [ELAPSED_W-1:0] elapsed_ms;
		logic                        idle_flag;
		logic                        vsync_flag;
	} arp_item_t;

endpackage

// ----- rtl/arp_if.sv -----
// arp_if: valid/ready channel interfaces for input beats and result beats
// depends on arp_pkg for field widths

interface arp_item_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [arp_pkg::ELAPSED_W-1:0] elapsed_ms;
	logic                                 idle_flag;
	logic                                 vsync_flag;

	modport source (output valid, output elapsed_ms, output idle_flag, output vsync_flag,
		input ready);
	modport sink (input valid, input elapsed_ms, input idle_flag, input vsync_flag,
		output ready);
endinterface

interface arp_result_if;
	logic                          valid;
	logic                          ready;
	logic [arp_pkg::WAIT_W-1:0]    wait_ms;

	modport source (output valid, output wait_ms, input ready);
	modport sink (input valid, input wait_ms, output ready);
endinterface

// ----- rtl/adaptive_redraw_pacer_top.sv -----
// adaptive_redraw_pacer_top: frame pacer, input register, step logic, result register
// depends on arp_pkg, arp_if.sv (channel interfaces) and arp_step
// an accepted input beat passes through the input register, then the result register
// throughput: one beat per cycle while the result side is ready; the score/multiplier/period
// loop closes through arp_step (a 10x5 multiply, a compare and a subtract) into st_q
// reset: arst_n asynchronous, active low; clears the pipeline, loads score 0,
// multiplier 1, period 20 and optimal_period_ms 20
module adaptive_redraw_pacer_top #(
	parameter int MAX_MULT = arp_pkg::MAX_MULT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [arp_pkg::OPT_W-1:0]  cfg_wdata,
	arp_item_if.sink                   item,
	arp_result_if.source               result
);

	// configuration register
	logic [arp_pkg::OPT_W-1:0] opt_q;

	// input stage
	logic               valid_s1;
	arp_pkg::arp_item_t item_s1;

	// pacing state
	arp_pkg::arp_state_t st_q;
	arp_pkg::arp_state_t st_nxt;

	// result stage
	logic                        valid_s2;
	logic [arp_pkg::WAIT_W-1:0]  wait_s2;
	logic [arp_pkg::WAIT_W-1:0]  wait_nxt;

	logic slot_free;
	logic fire;

	// result slot is free when empty or its beat leaves this cycle
	assign slot_free = !valid_s2 || result.ready;
	// the item in the input stage is processed and the state advances
	assign fire      = valid_s1 && slot_free;
	// input stage takes a new beat when empty or draining this cycle
	assign item.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_q <= arp_pkg::OPT_RESET;
		end else if (cfg_we) begin
			opt_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.elapsed_ms <= item.elapsed_ms;
			item_s1.idle_flag  <= item.idle_flag;
			item_s1.vsync_flag <= item.vsync_flag;
		end
	end

	arp_step #(
		.MAX_MULT (MAX_MULT)
	) u_step (
		.st      (st_q),
		.opt     (opt_q),
		.item    (item_s1),
		.st_nxt  (st_nxt),
		.wait_ms (wait_nxt)
	);

	// pacing state, updated once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.score  <= '0;
			st_q.mult   <= arp_pkg::MULT_ONE;
			st_q.period <= arp_pkg::PERIOD_RESET;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (slot_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			wait_s2 <= wait_nxt;
		end
	end

	assign result.valid   = valid_s2;
	assign result.wait_ms = wait_s2;

	// multiplier stays within its range
	mult_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mult >= arp_pkg::MULT_ONE && st_q.mult <= arp_pkg::MULT_W'(MAX_MULT))
		else $error("multiplier out of range");

	// a delivered wait time is never zero
	wait_nonzero_a: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> wait_s2 != '0)
		else $error("zero wait time");

	// idle or vsync with a raised multiplier returns the period to optimal
	idle_reset_a: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item_s1.idle_flag || item_s1.vsync_flag) && st_q.mult > arp_pkg::MULT_ONE
		|=> st_q.period == arp_pkg::PERIOD_W'($past(opt_q)))
		else $error("period not restored on idle or vsync");

	// a held input beat is not dropped while the result slot is blocked
	hold_s1_a: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1)
		else $error("input stage beat lost");

endmodule

// ----- rtl/arp_step.sv -----
// arp_step: next pacing state and wait time for one frame report
// depends on arp_pkg (state and item types, limits)
module arp_step #(
	parameter int MAX_MULT = arp_pkg::MAX_MULT_DEF
) (
	input  arp_pkg::arp_state_t              st,
	input  logic [arp_pkg::OPT_W-1:0]        opt,
	input  arp_pkg::arp_item_t               item,
	output arp_pkg::arp_state_t              st_nxt,
	output logic [arp_pkg::WAIT_W-1:0]       wait_ms
);

	logic [arp_pkg::DIFF_W-1:0]   diff;
	logic [arp_pkg::DIFF_W-1:0]   diff_eff;
	logic [arp_pkg::DIFF_W-1:0]   period_ext;
	logic [arp_pkg::MULT_W-1:0]   mult_up;
	logic [arp_pkg::MULT_W-1:0]   mult_dn;
	logic [arp_pkg::PROD_W-1:0]   next_up;
	logic [arp_pkg::PROD_W-1:0]   next_dn;
	logic [arp_pkg::PERIOD_W-1:0] sat_up;
	logic [arp_pkg::PERIOD_W-1:0] sat_dn;
	logic signed [arp_pkg::SCORE_W-1:0] s_clamp;
	logic signed [arp_pkg::SCORE_W-1:0] s_step;
	logic [arp_pkg::DIFF_W-1:0]   per_new_ext;

	// negative elapsed counts as zero
	assign diff = item.elapsed_ms[arp_pkg::ELAPSED_W-1] ? '0
		: item.elapsed_ms[arp_pkg::DIFF_W-1:0];
	assign period_ext = arp_pkg::DIFF_W'(st.period);

	assign mult_up = st.mult + arp_pkg::MULT_ONE;
	assign mult_dn = st.mult - arp_pkg::MULT_ONE;
	assign next_up = arp_pkg::PROD_W'(opt) * arp_pkg::PROD_W'(mult_up);
	assign next_dn = arp_pkg::PROD_W'(opt) * arp_pkg::PROD_W'(mult_dn);
	assign sat_up  = next_up[arp_pkg::PROD_W-1] ? arp_pkg::PERIOD_MAX
		: next_up[arp_pkg::PERIOD_W-1:0];
	assign sat_dn  = next_dn[arp_pkg::PROD_W-1] ? arp_pkg::PERIOD_MAX
		: next_dn[arp_pkg::PERIOD_W-1:0];

	always_comb begin
		st_nxt   = st;
		diff_eff = diff;
		s_clamp  = st.score;
		s_step   = st.score;
		if (item.idle_flag || item.vsync_flag) begin
			if (st.mult > arp_pkg::MULT_ONE) begin
				st_nxt.score  = arp_pkg::SCORE_LOW_LIMIT;
				st_nxt.period = arp_pkg::PERIOD_W'(opt);
				st_nxt.mult   = mult_dn;
			end
		end else if (diff > period_ext) begin
			// late frame
			s_clamp      = (st.score > 0) ? '0 : st.score;
			st_nxt.score = s_clamp;
			if (diff > next_up) begin
				s_step       = (s_clamp == arp_pkg::SCORE_MIN) ? s_clamp : s_clamp - 8'sd1;
				st_nxt.score = s_step;
				if (s_step < arp_pkg::SCORE_LOW_LIMIT &&
						st.mult < arp_pkg::MULT_W'(MAX_MULT)) begin
					st_nxt.mult   = mult_up;
					st_nxt.period = sat_up;
					diff_eff      = next_up;
				end
			end
		end else if (diff < period_ext) begin
			// early frame
			s_clamp      = (st.score < 0) ? '0 : st.score;
			st_nxt.score = s_clamp;
			if (st.mult > arp_pkg::MULT_ONE && diff < next_dn) begin
				s_step       = (s_clamp == arp_pkg::SCORE_MAX) ? s_clamp : s_clamp + 8'sd1;
				st_nxt.score = s_step;
				if (s_step > arp_pkg::SCORE_HIGH_LIMIT) begin
					st_nxt.mult   = mult_dn;
					st_nxt.period = sat_dn;
				end
			end
		end
	end

	assign per_new_ext = arp_pkg::DIFF_W'(st_nxt.period);
	assign wait_ms = (diff_eff >= per_new_ext) ? arp_pkg::WAIT_MIN
		: arp_pkg::WAIT_W'(per_new_ext - diff_eff);

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for adaptive_redraw_pacer_top, with directed and random beats
// depends on arp_pkg, the channel interfaces in arp_if.sv and the pacer rtl

module tb_top;

	// bench knobs
	localparam int MULT_LIMIT   = arp_pkg::MAX_MULT_DEF;
	localparam int IDLE_PCT     = 29;
	localparam int LATENCY      = 2;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASE_BEATS  = 216;
	localparam int NUM_PHASES   = 8;
	localparam int DIR_ROWS     = 15;
	localparam int ELAPSED_TOP  = 32767;

	// kinds of random bursts
	typedef enum int {
		KIND_LATE,
		KIND_EARLY,
		KIND_FLAGS,
		KIND_EQUAL,
		KIND_NOISE
	} burst_kind_t;

	// one row of the directed sequence; a typed wait is used in place of the predictor
	typedef struct {
		logic signed [arp_pkg::ELAPSED_W-1:0] elapsed;
		logic                                 idle;
		logic                                 vsync;
		int                                   reps;
		bit                                   typed;
		int                                   wait_val;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [arp_pkg::OPT_W-1:0] cfg_wdata;

	arp_item_if   item_ch();
	arp_result_if result_ch();

	adaptive_redraw_pacer_top #(
		.MAX_MULT(MULT_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	// pacer state as the bench tracks it, updated at each accepted input beat
	logic signed [arp_pkg::SCORE_W-1:0] pacer_score;
	logic [arp_pkg::MULT_W-1:0]         pacer_mult;
	logic [arp_pkg::PERIOD_W-1:0]       pacer_period;
	logic [arp_pkg::OPT_W-1:0]          pacer_opt;

	// expected wait_ms values, oldest first
	logic [arp_pkg::WAIT_W-1:0] wait_ms_q[$];

	int mismatch_count;
	bit calm;           // no idling on either side while set
	bit hold_request;   // asks the result side for a long hold-off
	int hold_left;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// after reset: optimal 20, period 20, multiplier 1, score 0
		'{16'sd0,     1'b0, 1'b0, 1, 1'b1, 20},
		'{16'sh8000,  1'b0, 1'b0, 1, 1'b1, 20},  // most negative counts as zero
		'{16'shFFFF,  1'b0, 1'b0, 1, 1'b1, 20},
		'{16'sd20,    1'b0, 1'b0, 1, 1'b1, 1},   // exactly due
		'{16'sd19,    1'b0, 1'b0, 1, 1'b1, 1},
		'{16'sd32767, 1'b0, 1'b0, 1, 1'b1, 1},   // late, score -1
		'{16'sd32767, 1'b0, 1'b0, 1, 1'b1, 1},   // late again, multiplier grows
		'{16'sd0,     1'b1, 1'b0, 1, 1'b1, 20},  // idle steps the multiplier back
		'{16'sd5,     1'b0, 1'b1, 1, 1'b1, 15},  // vsync with multiplier 1: no change
		'{16'sd32767, 1'b1, 1'b1, 1, 1'b1, 1},
		'{16'sd100,   1'b0, 1'b0, 6, 1'b0, 0},   // late ramp until the period catches up
		'{16'sd0,     1'b0, 1'b0, 6, 1'b0, 0},   // early frames shrink the multiplier
		'{16'sh4000,  1'b0, 1'b0, 1, 1'b0, 0},
		'{16'sh2AAA,  1'b0, 1'b0, 1, 1'b0, 0},
		'{16'sh5555,  1'b0, 1'b0, 1, 1'b0, 0}
	};

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("adaptive_redraw_pacer_top regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// advance the tracked pacer state by one beat and return the expected wait
	function automatic logic [arp_pkg::WAIT_W-1:0] advance_pacer(input arp_pkg::arp_item_t beat);
		int diff;
		int nxt;
		int score;
		int mult;
		int period;
		int opt;
		score  = int'(pacer_score);
		mult   = int'(pacer_mult);
		period = int'(pacer_period);
		opt    = int'(pacer_opt);
		// negative elapsed counts as zero
		diff = beat.elapsed_ms[arp_pkg::ELAPSED_W-1] ? 0
			: int'(beat.elapsed_ms[arp_pkg::ELAPSED_W-2:0]);
		if (beat.idle_flag || beat.vsync_flag) begin
			if (mult > 1) begin
				score  = -1;
				period = opt;
				mult   = mult - 1;
			end
		end else if (diff > period) begin
			if (score > 0)
				score = 0;
			nxt = opt * (mult + 1);
			if (diff > nxt) begin
				if (score > -128)
					score = score - 1;
				// growth is skipped once the multiplier is at its limit
				if (score < -1 && mult < MULT_LIMIT) begin
					mult   = mult + 1;
					period = (nxt > 16383) ? 16383 : nxt;
					diff   = nxt;
				end
			end
		end else if (diff < period) begin
			if (score < 0)
				score = 0;
			if (mult > 1) begin
				nxt = opt * (mult - 1);
				if (diff < nxt) begin
					if (score < 127)
						score = score + 1;
					if (score > 4) begin
						mult   = mult - 1;
						period = (nxt > 16383) ? 16383 : nxt;
					end
				end
			end
		end
		pacer_score  = arp_pkg::SCORE_W'(score);
		pacer_mult   = arp_pkg::MULT_W'(mult);
		pacer_period = arp_pkg::PERIOD_W'(period);
		if (diff >= period)
			return arp_pkg::WAIT_MIN;
		return arp_pkg::WAIT_W'(period - diff);
	endfunction

	// build one random beat aimed at the current state
	function automatic arp_pkg::arp_item_t pick_beat(input burst_kind_t kind);
		arp_pkg::arp_item_t beat;
		int base;
		int val;
		beat.idle_flag  = 1'b0;
		beat.vsync_flag = 1'b0;
		case (kind)
			KIND_LATE: begin
				base = int'(pacer_opt) * (int'(pacer_mult) + 1 + $urandom_range(0, 2));
				val  = base + $urandom_range(1, 40);
				if (val > ELAPSED_TOP)
					val = ELAPSED_TOP;
			end
			KIND_EARLY: begin
				base = int'(pacer_opt) *
					((pacer_mult > arp_pkg::MULT_ONE) ? int'(pacer_mult) - 1 : 1);
				val  = (base > 0) ? $urandom_range(0, base - 1) : 0;
			end
			KIND_FLAGS: begin
				val = $urandom_range(0, 2000);
				case ($urandom_range(0, 2))
					0: beat.idle_flag = 1'b1;
					1: beat.vsync_flag = 1'b1;
					default: begin
						beat.idle_flag  = 1'b1;
						beat.vsync_flag = 1'b1;
					end
				endcase
			end
			KIND_EQUAL: begin
				val = int'(pacer_period) + $urandom_range(0, 2) - 1;
				if (val < 0)
					val = 0;
			end
			default: begin
				// anything the field allows, negatives included
				val = $urandom_range(0, 65535);
				beat.idle_flag  = ($urandom_range(0, 3) == 0);
				beat.vsync_flag = ($urandom_range(0, 3) == 0);
			end
		endcase
		beat.elapsed_ms = arp_pkg::ELAPSED_W'(val);
		return beat;
	endfunction

	// offer one input beat, with random idle cycles ahead of it; predict at acceptance
	task automatic send_beat(input arp_pkg::arp_item_t beat, input bit typed,
		input int typed_wait);
		logic [arp_pkg::WAIT_W-1:0] predicted;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.elapsed_ms <= beat.elapsed_ms;
		item_ch.idle_flag  <= beat.idle_flag;
		item_ch.vsync_flag <= beat.vsync_flag;
		do
			@(posedge clk);
		while (!item_ch.ready);
		predicted = advance_pacer(beat);
		if (typed)
			predicted = arp_pkg::WAIT_W'(typed_wait);
		wait_ms_q = {wait_ms_q, predicted};
	endtask

	// drop valid and wait until every expected beat has come back
	task automatic drain_results();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (wait_ms_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 1) @(posedge clk);
	endtask

	task automatic write_optimal(input logic [arp_pkg::OPT_W-1:0] val);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		pacer_opt = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, a long hold-off on request, none while calm
	initial begin
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		logic [arp_pkg::WAIT_W-1:0] want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (wait_ms_q.size() == 0) begin
				report_mismatch($sformatf("result beat wait_ms %0d with nothing expected",
					result_ch.wait_ms));
			end else begin
				want = wait_ms_q.pop_front();
				if (result_ch.wait_ms !== want)
					report_mismatch($sformatf("wait_ms got %0d want %0d",
						result_ch.wait_ms, want));
			end
		end
	end

	// main sequence
	initial begin
		arp_pkg::arp_item_t beat;
		burst_kind_t kind;
		logic [arp_pkg::OPT_W-1:0] phase_opt [NUM_PHASES];
		int burst_len;
		int sent;
		int pick;

		// every input known from time zero
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		item_ch.valid      = 1'b0;
		item_ch.elapsed_ms = '0;
		item_ch.idle_flag  = 1'b0;
		item_ch.vsync_flag = 1'b0;
		result_ch.ready    = 1'b0;
		mismatch_count     = 0;
		calm               = 1'b0;
		hold_request       = 1'b0;

		pacer_score  = '0;
		pacer_mult   = arp_pkg::MULT_ONE;
		pacer_period = arp_pkg::PERIOD_RESET;
		pacer_opt    = arp_pkg::OPT_RESET;

		// extremes first, a typical rate in the middle, then random ones and a last fixed one
		phase_opt[0] = 10'd1;
		phase_opt[1] = 10'd1023;
		phase_opt[2] = 10'd0;
		phase_opt[3] = 10'd16;
		phase_opt[4] = 10'd1000;
		phase_opt[5] = arp_pkg::OPT_W'($urandom_range(1, 100));
		phase_opt[6] = arp_pkg::OPT_W'($urandom_range(0, 1023));
		phase_opt[7] = 10'd7;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows at the reset settings
		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				beat.elapsed_ms = dir_rows[r].elapsed;
				beat.idle_flag  = dir_rows[r].idle;
				beat.vsync_flag = dir_rows[r].vsync;
				send_beat(beat, dir_rows[r].typed, dir_rows[r].wait_val);
			end
		end

		// random phases, one optimal period each
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_optimal(phase_opt[ph]);
			calm = (ph == 3);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				// mostly well-formed late and early runs, some flags, some noise
				pick = $urandom_range(0, 99);
				if (pick < 35)
					kind = KIND_LATE;
				else if (pick < 65)
					kind = KIND_EARLY;
				else if (pick < 77)
					kind = KIND_FLAGS;
				else if (pick < 87)
					kind = KIND_EQUAL;
				else
					kind = KIND_NOISE;
				burst_len = $urandom_range(1, 6);
				// an occasional long late run drives the score to its floor
				if (kind == KIND_LATE && $urandom_range(0, 19) == 0)
					burst_len = 140;
				for (int k = 0; k < burst_len && sent < PHASE_BEATS; k++) begin
					// long hold-off while beats keep coming, fills the pipeline
					if ((ph == 1 || ph == 5) && sent == 50)
						hold_request = 1'b1;
					// sender waits for every outstanding result mid-phase
					if (ph == 6 && sent == 100)
						drain_results();
					send_beat(pick_beat(kind), 1'b0, 0);
					sent++;
				end
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("adaptive_redraw_pacer_top regression: pass");
		else
			$display("adaptive_redraw_pacer_top regression: fail");
		$finish;
	end

endmodule
